FILE: rtl/core/rht_pkg.sv
package rht_pkg;

  localparam logic [31:0] INVALID_ID = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    FN_ADD     = 3'd0,
    FN_REMOVE  = 3'd1,
    FN_GET     = 3'd2,
    FN_HOLD    = 3'd3,
    FN_RELEASE = 3'd4,
    FN_EXISTS  = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_DEAD        = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_DUPLICATE   = 3'd3,
    ST_UNAVAILABLE = 3'd4,
    ST_FULL        = 3'd5,
    ST_UNDERFLOW   = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_RMW  = 4'b1000
  } state_t;

endpackage

FILE: rtl/core/rht_if.sv
interface rht_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] context_id;
  logic [31:0] resource_id;
  logic [5:0]  slot;
  modport source (output valid, func, context_id, resource_id, slot, input ready);
  modport sink (input valid, func, context_id, resource_id, slot, output ready);
endinterface

interface rht_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [5:0]  result_slot;
  logic [15:0] ref_count;
  modport source (output valid, status, found, result_slot, ref_count, input ready);
  modport sink (input valid, status, found, result_slot, ref_count, output ready);
endinterface

interface rht_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/rht_mem.sv
module rht_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/refcounted_handle_table.sv
// channel | dir | payload
// req     | in  | func, context_id, resource_id, slot
// rsp     | out | status, found, result_slot, ref_count
// cfg     | in  | data (create_enable)
// add, get, exists: scan every slot of the entry memory, one read per slot, then finish.
// remove, hold, release: read, modify and write back one entry.
// Unused codes, refused add, out of range slot, invalid get: answered from idle, with no scan or write back.
// One item at a time; req waits until the previous result has left rsp.
// rst clears link and allocation bits and sets create_enable; no clearing pass.
module refcounted_handle_table
  import rht_pkg::*;
#(
  parameter int TABLE_SLOTS = 64,
  parameter int REF_BITS    = 16
) (
  input  logic clk,
  input  logic rst,
  rht_req_if.sink   req,
  rht_rsp_if.source rsp,
  rht_cfg_if.sink   cfg
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int RW = 64 + REF_BITS;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [SW:0] LAST = (SW+1)'(TABLE_SLOTS - 1);

  state_t state;
  logic create_enable;
  logic [TABLE_SLOTS-1:0] linked;
  logic [TABLE_SLOTS-1:0] allocated;

  logic [2:0]  func;
  logic [31:0] ctx;
  logic [31:0] res;
  logic [SW-1:0] idx;

  logic [SW:0]   iss;
  logic          chk_vld;
  logic [SW-1:0] chk_idx;
  logic          hit;
  logic [SW-1:0] m_idx;
  logic [RW-1:0] m_row;
  logic          free_hit;
  logic [SW-1:0] free_idx;

  logic          out_valid;
  logic [2:0]    out_status;
  logic          out_found;
  logic [5:0]    out_slot;
  logic [15:0]   out_refs;

  logic          we;
  logic [SW-1:0] waddr;
  logic [RW-1:0] wdata;
  logic          re;
  logic [SW-1:0] raddr;
  logic [RW-1:0] rdata;

  logic [31:0]         r_ctx;
  logic [31:0]         r_res;
  logic [REF_BITS-1:0] r_refs;
  logic                match;
  logic [REF_BITS-1:0] m_refs;
  logic [REF_BITS-1:0] m_inc;
  logic [REF_BITS-1:0] r_inc;
  logic [REF_BITS-1:0] r_dec;
  logic                slot_ok;

  rht_mem #(.DEPTH(TABLE_SLOTS), .WIDTH(RW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign req.ready       = (state == S_IDLE) && !out_valid;
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found       = out_found;
  assign rsp.result_slot = out_slot;
  assign rsp.ref_count   = out_refs;

  assign r_ctx  = rdata[RW-1 -: 32];
  assign r_res  = rdata[RW-33 -: 32];
  assign r_refs = rdata[REF_BITS-1:0];
  assign m_refs = m_row[REF_BITS-1:0];
  assign m_inc  = (m_refs == REF_MAX) ? m_refs : m_refs + REF_BITS'(1);
  assign r_inc  = (r_refs == REF_MAX) ? r_refs : r_refs + REF_BITS'(1);
  assign r_dec  = r_refs - REF_BITS'(1);
  assign slot_ok = 32'(req.slot) < 32'(TABLE_SLOTS);

  assign match = linked[chk_idx] && (r_res == res) &&
                 ((r_ctx == ctx) || (r_ctx == INVALID_ID) ||
                  ((func != FN_GET) && (ctx == INVALID_ID)));

  always_comb begin
    re    = 1'b0;
    raddr = iss[SW-1:0];
    if (state == S_IDLE) begin
      re    = req.valid && req.ready;
      raddr = SW'(req.slot);
    end else if (state == S_SCAN) begin
      re = iss < (SW+1)'(TABLE_SLOTS);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {r_ctx, r_res, r_refs};
    if (state == S_FIN) begin
      if (func == FN_ADD && !hit && free_hit) begin
        we    = 1'b1;
        waddr = free_idx;
        wdata = {ctx, res, REF_BITS'(1)};
      end else if (func == FN_GET && hit) begin
        we    = 1'b1;
        waddr = m_idx;
        wdata = {m_row[RW-1:REF_BITS], m_inc};
      end
    end else if (state == S_RMW) begin
      if (func == FN_HOLD) begin
        we    = allocated[idx];
        wdata = {r_ctx, r_res, r_inc};
      end else begin
        we    = (func == FN_REMOVE ? linked[idx] : allocated[idx]) && (r_refs != '0);
        wdata = {r_ctx, r_res, r_dec};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      create_enable <= 1'b1;
      linked        <= '0;
      allocated     <= '0;
      out_valid     <= 1'b0;
      chk_vld       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        create_enable <= cfg.data;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            func       <= req.func;
            ctx        <= req.context_id;
            res        <= req.resource_id;
            idx        <= SW'(req.slot);
            iss        <= '0;
            hit        <= 1'b0;
            free_hit   <= 1'b0;
            chk_vld    <= 1'b0;
            out_status <= (req.func == FN_ADD && !create_enable) ? ST_UNAVAILABLE
                                                                 : ST_NOT_FOUND;
            out_found  <= 1'b0;
            out_slot   <= '0;
            out_refs   <= '0;
            case (req.func)
              FN_ADD: begin
                if (create_enable) begin
                  state <= S_SCAN;
                end else begin
                  out_valid  <= 1'b1;
                end
              end
              FN_EXISTS: state <= S_SCAN;
              FN_GET: begin
                if (req.context_id == INVALID_ID && req.resource_id == INVALID_ID) begin
                  out_valid <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              FN_REMOVE, FN_HOLD, FN_RELEASE: begin
                if (slot_ok) begin
                  state <= S_RMW;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_SCAN: begin
          if (iss < (SW+1)'(TABLE_SLOTS)) begin
            if (!allocated[iss[SW-1:0]] && !free_hit) begin
              free_hit <= 1'b1;
              free_idx <= iss[SW-1:0];
            end
            iss <= iss + (SW+1)'(1);
          end
          chk_vld <= iss < (SW+1)'(TABLE_SLOTS);
          chk_idx <= iss[SW-1:0];
          if (chk_vld) begin
            if (match && !hit) begin
              hit   <= 1'b1;
              m_idx <= chk_idx;
              m_row <= rdata;
            end
            if ((SW+1)'(chk_idx) == LAST) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          case (func)
            FN_ADD: begin
              if (hit) begin
                out_status <= ST_DUPLICATE;
              end else if (!free_hit) begin
                out_status <= ST_FULL;
              end else begin
                out_status          <= ST_OK;
                out_slot            <= 6'(free_idx);
                out_refs            <= 16'd1;
                linked[free_idx]    <= 1'b1;
                allocated[free_idx] <= 1'b1;
              end
            end
            FN_GET: begin
              if (hit) begin
                out_status <= ST_OK;
                out_found  <= 1'b1;
                out_slot   <= 6'(m_idx);
                out_refs   <= 16'(m_inc);
              end
            end
            default: begin
              out_status <= ST_OK;
              out_found  <= hit;
            end
          endcase
        end
        S_RMW: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          case (func)
            FN_HOLD: begin
              if (allocated[idx]) begin
                out_status <= ST_OK;
                out_refs   <= 16'(r_inc);
              end
            end
            default: begin
              if (func == FN_REMOVE ? linked[idx] : allocated[idx]) begin
                if (r_refs == '0) begin
                  out_status <= ST_UNDERFLOW;
                end else begin
                  out_refs <= 16'(r_dec);
                  if (func == FN_REMOVE || r_dec == '0) begin
                    linked[idx] <= 1'b0;
                  end
                  if (r_dec == '0) begin
                    out_status     <= ST_DEAD;
                    allocated[idx] <= 1'b0;
                  end else begin
                    out_status <= ST_OK;
                  end
                end
              end
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
